### src/gyro_calibrate_deadband_unit_assert.svh
// Assertion macros for the gyro calibration block checker.
// Depends on nothing; included by the checker file.
`ifndef GYRO_CALIBRATE_DEADBAND_UNIT_ASSERT_SVH
`define GYRO_CALIBRATE_DEADBAND_UNIT_ASSERT_SVH
// check an implication every clock, off during reset
`define GCD_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
// check an implication in the cycle after, off during reset
`define GCD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`endif

### src/gcd_pkg.sv
// Shared types and constants for the gyro calibration block.
// No dependencies.
package gcd_pkg;
   localparam int RAW_W  = 16;
   localparam int RATE_W = 21;
   localparam int CNT_W  = 11;
   localparam int FAC_W  = 20;
   localparam int MAX_CALIB = 1024;
   localparam int FRAC = 8;
   localparam int SUM_W  = 27;
   localparam int SQ_W   = 41;
   localparam int BIAS_W = 25;
   localparam int SIG_W  = 24;
   localparam int VAR_W  = 68;

   localparam logic [1:0] CSR_SCALE  = 2'd0;
   localparam logic [1:0] CSR_CALIB  = 2'd1;
   localparam logic [1:0] CSR_THRESH = 2'd2;

   localparam logic OP_CALIB   = 1'b0;
   localparam logic OP_MEASURE = 1'b1;

   // per-digit dps factor, unsigned Q24
   function automatic logic [FAC_W-1:0] dps_factor(input logic [1:0] sel);
      logic [FAC_W-1:0] f;
      unique case (sel)
         2'd0: f = 20'd128060;
         2'd1: f = 20'd256138;
         2'd2: f = 20'd511487;
         default: f = 20'd1022991;
      endcase
      return f;
   endfunction

   // datapath commands from the controller
   typedef struct packed {
      logic       load;      // capture input item
      logic       acc;       // add item to sums (one axis per step)
      logic       meas;      // run one measurement axis
      logic [1:0] axis;
      logic       div_start; // start end-of-calibration work on an axis
      logic       finish;    // store bias/sigma, clear sums; last axis sets calibrated
      logic       out_load;  // move result to output register
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic calib_done;  // sample count reached limit
   } stat_type;
endpackage

### src/gcd_math.sv
// Multi-cycle bias divide, variance divide and square root for one axis.
// Depends on gcd_pkg.
module gcd_math import gcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  sum,
   input  logic [SQ_W-1:0]          sq_sum,
   input  logic [CNT_W-1:0]         count,
   output logic                     busy,
   output logic signed [BIAS_W-1:0] bias,
   output logic [SIG_W-1:0]         sigma
);
   localparam logic [2:0] M_IDLE = 3'd0, M_PREP = 3'd1, M_BDIV = 3'd2,
                          M_VDIV = 3'd3, M_SQRT = 3'd4, M_DONE = 3'd5;
   logic [2:0]  st_ff, st_in;
   logic [6:0]  k_ff, k_in;
   logic [36:0] bnum_ff, bnum_in;   // |sum|<<8
   logic [36:0] brem_ff, brem_in;
   logic [36:0] bq_ff, bq_in;
   logic [VAR_W-1:0] vnum_ff, vnum_in;
   logic [VAR_W-1:0] vrem_ff, vrem_in;
   logic [VAR_W-1:0] vq_ff, vq_in;
   logic [21:0] nn_ff, nn_in;
   logic [VAR_W-1:0] sr_v_ff, sr_v_in, sr_r_ff, sr_r_in;
   logic neg_ff, neg_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [52:0] prod, sq2;
   logic [26:0] mag;
   logic [37:0] btry;
   logic [VAR_W:0] vtry;
   logic [VAR_W-1:0] sbit, stry;
   logic [37:0] twice;
   logic [36:0] bround;

   assign mag  = sum[SUM_W-1] ? 27'(-sum) : 27'(sum);
   // prod/sq2 used once in prep; divider and root step per cycle
   assign prod = 53'(count) * 53'(sq_sum);
   assign sq2  = 53'(mag) * 53'(mag);
   assign btry = {brem_ff, bnum_ff[36 - k_ff[5:0]]};
   assign vtry = {vrem_ff, vnum_ff[7'(VAR_W-1) - k_ff]};
   assign sbit = VAR_W'(1) << (7'd62 - {k_ff[5:0], 1'b0});
   assign stry = sr_r_ff + sbit;
   assign twice = {brem_ff, 1'b0};
   assign bround = (twice >= 38'(n_ff)) ? bq_ff + 37'd1 : bq_ff;

   always_comb begin
      st_in = st_ff; k_in = k_ff; bnum_in = bnum_ff; brem_in = brem_ff; bq_in = bq_ff;
      vnum_in = vnum_ff; vrem_in = vrem_ff; vq_in = vq_ff; nn_in = nn_ff;
      sr_v_in = sr_v_ff; sr_r_in = sr_r_ff; neg_in = neg_ff; n_in = n_ff;
      unique case (st_ff)
         M_IDLE: if (start) begin
            st_in = M_PREP; neg_in = sum[SUM_W-1]; n_in = count;
            bnum_in = {2'b0, mag, 8'b0};
            nn_in = 22'(count) * 22'(count);
         end
         M_PREP: begin
            // variance numerator count*sumsq - sum^2, scaled by 2^16
            vnum_in = (prod > sq2) ? VAR_W'({prod - sq2, 16'b0}) : '0;
            brem_in = '0; bq_in = '0; vrem_in = '0; vq_in = '0; k_in = '0;
            st_in = M_BDIV;
         end
         M_BDIV: begin
            if (btry >= 38'(n_ff)) begin
               brem_in = 37'(btry - 38'(n_ff)); bq_in = {bq_ff[35:0], 1'b1};
            end else begin
               brem_in = btry[36:0]; bq_in = {bq_ff[35:0], 1'b0};
            end
            k_in = k_ff + 7'd1;
            if (k_ff == 7'd36) begin st_in = M_VDIV; k_in = '0; end
         end
         M_VDIV: begin
            if (vtry >= (VAR_W+1)'(nn_ff)) begin
               vrem_in = VAR_W'(vtry - (VAR_W+1)'(nn_ff));
               vq_in = {vq_ff[VAR_W-2:0], 1'b1};
            end else begin
               vrem_in = vtry[VAR_W-1:0]; vq_in = {vq_ff[VAR_W-2:0], 1'b0};
            end
            k_in = k_ff + 7'd1;
            if (k_ff == 7'(VAR_W-1)) begin
               st_in = M_SQRT; k_in = '0; sr_r_in = '0; sr_v_in = vq_in;
            end
         end
         M_SQRT: begin
            if (sr_v_ff >= stry) begin
               sr_v_in = sr_v_ff - stry; sr_r_in = (sr_r_ff >> 1) + sbit;
            end else sr_r_in = sr_r_ff >> 1;
            k_in = k_ff + 7'd1;
            if (k_ff == 7'd31) st_in = M_DONE;
         end
         default: st_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= M_IDLE; k_ff <= '0;
      end else begin
         st_ff <= st_in; k_ff <= k_in;
      end
      bnum_ff <= bnum_in; brem_ff <= brem_in; bq_ff <= bq_in;
      vnum_ff <= vnum_in; vrem_ff <= vrem_in; vq_ff <= vq_in; nn_ff <= nn_in;
      sr_v_ff <= sr_v_in; sr_r_ff <= sr_r_in; neg_ff <= neg_in; n_ff <= n_in;
   end

   assign busy  = (st_ff != M_IDLE) && (st_ff != M_DONE);
   assign bias  = neg_ff ? -BIAS_W'(bround) : BIAS_W'(bround);
   assign sigma = sr_r_ff[SIG_W-1:0];
endmodule

### src/gcd_datapath.sv
// Datapath: sums, bias/sigma store, shared multiplier, output register.
// Depends on gcd_pkg and gcd_math.
module gcd_datapath import gcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [1:0]               scale,
   input  logic [CNT_W-1:0]         calib_n,
   input  logic [7:0]               thresh,
   input  logic                     op,
   input  logic signed [RAW_W-1:0]  raw_x,
   input  logic signed [RAW_W-1:0]  raw_y,
   input  logic signed [RAW_W-1:0]  raw_z,
   output logic signed [RATE_W-1:0] rate_x,
   output logic signed [RATE_W-1:0] rate_y,
   output logic signed [RATE_W-1:0] rate_z,
   output logic                     cal_out
);
   logic signed [RAW_W-1:0]  raw_ff [3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic [SQ_W-1:0]          sq_ff [3];
   logic signed [BIAS_W-1:0] bias_ff [3];
   logic [SIG_W-1:0]         sig_ff [3];
   logic signed [RATE_W-1:0] res_ff [3];
   logic signed [RATE_W-1:0] out_ff [3];
   logic [CNT_W-1:0] cnt_ff;
   logic cal_ff, calo_ff;
   logic [CNT_W-1:0] lim;
   logic [1:0] dax_ff;
   logic signed [RAW_W-1:0] r;
   logic signed [BIAS_W:0] d;
   logic [BIAS_W-1:0] dmag;
   logic [31:0] thr;
   logic [44:0] p;
   logic [21:0] pr;
   logic signed [RATE_W:0] rs;
   logic signed [RATE_W-1:0] rsat;
   logic m_busy;
   logic signed [BIAS_W-1:0] m_bias;
   logic [SIG_W-1:0] m_sig;

   assign lim = (calib_n == '0) ? CNT_W'(1) :
                (calib_n > CNT_W'(MAX_CALIB)) ? CNT_W'(MAX_CALIB) : calib_n;
   assign stat.calib_done = (cnt_ff >= lim);
   assign stat.div_busy = m_busy;

   gcd_math u_math (.clock, .reset, .start(cmd.div_start),
      .sum(sum_ff[cmd.axis]), .sq_sum(sq_ff[cmd.axis]), .count(cnt_ff),
      .busy(m_busy), .bias(m_bias), .sigma(m_sig));

   // one axis per step: bias removal, deadband, scaling
   assign r = raw_ff[cmd.axis];
   assign d = ((BIAS_W+1)'(r) <<< FRAC) - (cal_ff ? (BIAS_W+1)'(bias_ff[cmd.axis]) : '0);
   assign dmag = d[BIAS_W] ? BIAS_W'(-d) : BIAS_W'(d);
   assign thr = 32'(sig_ff[cmd.axis]) * 32'(thresh);
   assign p = ((thresh != 8'd0) && (32'(dmag) < thr)) ? '0 :
              45'(dmag) * 45'(dps_factor(scale));
   assign pr = 22'((p + 45'(1 << 23)) >> 24);
   assign rs = d[BIAS_W] ? -(RATE_W+1)'(pr) : (RATE_W+1)'(pr);
   assign rsat = (rs > (RATE_W+1)'(1048575)) ? RATE_W'(1048575) :
                 (rs < -(RATE_W+1)'(1048576)) ? RATE_W'(-1048576) : RATE_W'(rs);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0; sq_ff[a] <= '0; bias_ff[a] <= '0; sig_ff[a] <= '0;
         end
         cnt_ff <= '0; cal_ff <= 1'b0; dax_ff <= '0;
      end else begin
         if (cmd.load) begin
            raw_ff[0] <= raw_x; raw_ff[1] <= raw_y; raw_ff[2] <= raw_z;
            if (op == OP_CALIB) cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.acc) begin
            sum_ff[cmd.axis] <= sum_ff[cmd.axis] + SUM_W'(r);
            sq_ff[cmd.axis] <= sq_ff[cmd.axis] + SQ_W'(32'(r) * 32'(r));
         end
         if (cmd.div_start) dax_ff <= cmd.axis;
         // commit a finished axis once the unit reports idle after start
         if (cmd.finish) begin
            bias_ff[dax_ff] <= m_bias; sig_ff[dax_ff] <= m_sig;
            sum_ff[dax_ff] <= '0; sq_ff[dax_ff] <= '0;
            if (dax_ff == 2'd2) begin cnt_ff <= '0; cal_ff <= 1'b1; end
         end
      end
      if (cmd.meas) res_ff[cmd.axis] <= rsat;
      if (cmd.out_load) begin
         out_ff <= res_ff; calo_ff <= cal_ff;
      end
   end
   assign rate_x = out_ff[0];
   assign rate_y = out_ff[1];
   assign rate_z = out_ff[2];
   assign cal_out = calo_ff;
endmodule

### src/gcd_ctrl.sv
// Controller: sequences accumulate, calibration end and measurement steps.
// Depends on gcd_pkg.
module gcd_ctrl import gcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_operation,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);
   localparam logic [2:0] S_IDLE = 3'd0, S_ACC = 3'd1, S_DSTART = 3'd2,
                          S_DWAIT = 3'd3, S_MEAS = 3'd4, S_OUT = 3'd5;
   logic [2:0] st_ff, st_in;
   logic [1:0] ax_ff, ax_in;
   logic ov_ff, ov_in, wait_ff, wait_in;

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = ov_ff;

   always_comb begin
      st_in = st_ff; ax_in = ax_ff; wait_in = 1'b0;
      ov_in = ov_ff && !rsp_ready;
      cmd = '0; cmd.axis = ax_ff;
      unique case (st_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1; ax_in = '0;
            st_in = (req_operation == OP_CALIB) ? S_ACC : S_MEAS;
         end
         S_ACC: begin
            cmd.acc = 1'b1; ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               ax_in = '0;
               st_in = stat.calib_done ? S_DSTART : S_IDLE;
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1; st_in = S_DWAIT; wait_in = 1'b1;
         end
         S_DWAIT: if (!wait_ff && !stat.div_busy) begin
            cmd.finish = 1'b1; ax_in = ax_ff + 2'd1;
            st_in = (ax_ff == 2'd2) ? S_IDLE : S_DSTART;
            if (ax_ff == 2'd2) ax_in = '0;
         end
         S_MEAS: begin
            cmd.meas = 1'b1; ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin ax_in = '0; st_in = S_OUT; end
         end
         S_OUT: if (!ov_ff || rsp_ready) begin
            cmd.out_load = 1'b1; ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ax_ff <= '0; ov_ff <= 1'b0; wait_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ax_ff <= ax_in; ov_ff <= ov_in;
         wait_ff <= wait_in;
      end
   end
endmodule

### src/gyro_calibrate_deadband_unit.sv
// Top level of the gyro bias calibration and deadband block.
// Depends on gcd_pkg, gcd_ctrl, gcd_datapath.
//
// Usage:
//  - req_ channel carries one three-axis sample; operation 0 is a calibration
//    sample (no response), 1 a measurement sample (one rsp_ transfer).
//  - csr_ port writes gyro_scale (0), calib_samples (1), threshold_multiple (2);
//    the user writes them only while the block is idle; it is not enforced.
//  - A calibration sample takes a capture step plus one step per axis.
//    The last one of a calibration run adds per axis, in the bit-serial math
//    unit, a 37-step bias divide, a 68-step variance divide and a 32-step root.
//  - A measurement sample runs a capture, one step per axis on the
//    shared multiplier, then a move into the output register.
//  - The output register holds a result while rsp_ready is low; the next
//    sample is taken and processed meanwhile, stalling only at its own
//    output move.
//  - Synchronous reset clears sums, bias, sigma, the calibrated flag and the
//    registers to their reset values (scale 250 dps, 50 samples, no deadband).
module gyro_calibrate_deadband_unit import gcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [RAW_W-1:0]  req_raw_x,
   input  logic signed [RAW_W-1:0]  req_raw_y,
   input  logic signed [RAW_W-1:0]  req_raw_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [RATE_W-1:0] rsp_rate_x,
   output logic signed [RATE_W-1:0] rsp_rate_y,
   output logic signed [RATE_W-1:0] rsp_rate_z,
   output logic                     rsp_is_calibrated,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CNT_W-1:0]         csr_data
);
   logic [1:0] scale_ff;
   logic [CNT_W-1:0] calib_ff;
   logic [7:0] thresh_ff;
   cmd_type cmd;
   stat_type stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0; calib_ff <= CNT_W'(50); thresh_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCALE:  scale_ff <= csr_data[1:0];
            CSR_CALIB:  calib_ff <= csr_data;
            CSR_THRESH: thresh_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   gcd_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .req_operation,
      .rsp_valid, .rsp_ready, .cmd, .stat);

   gcd_datapath u_dp (.clock, .reset, .cmd, .stat,
      .scale(scale_ff), .calib_n(calib_ff), .thresh(thresh_ff),
      .op(req_operation), .raw_x(req_raw_x), .raw_y(req_raw_y), .raw_z(req_raw_z),
      .rate_x(rsp_rate_x), .rate_y(rsp_rate_y), .rate_z(rsp_rate_z),
      .cal_out(rsp_is_calibrated));
endmodule

### src/gcd_checker.sv
// Port-level checker for the gyro calibration block, bound to the top level.
// Depends on gyro_calibrate_deadband_unit_assert.svh.
`include "gyro_calibrate_deadband_unit_assert.svh"
module gcd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_calibrated
);
   // a stalled response holds
   `GCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // hold the calibrated flag of a stalled response
   `GCD_ASSERT_NEXT(a_cal_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_is_calibrated))
   // block is busy right after taking a sample
   `GCD_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready)
   // no response right out of reset
   `GCD_ASSERT_NEXT(a_rst_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule

bind gyro_calibrate_deadband_unit gcd_checker u_chk (.clock, .reset, .req_valid,
   .req_ready, .rsp_valid, .rsp_ready, .rsp_is_calibrated);

### tb/gyro_calibrate_deadband_unit_tb.sv
// Self-checking testbench for gyro_calibrate_deadband_unit: bias/sigma calibration,
// deadband and dps scaling checked against a built-in rate predictor.
// Depends on gcd_pkg and the gyro_calibrate_deadband_unit RTL.
module gyro_calibrate_deadband_unit_tb;
   import gcd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 600;

   typedef struct {
      logic signed [RATE_W-1:0] x, y, z;
      logic                     cal;
   } rate_rec_type;

   // Predicts rates from accepted samples and checks returned transfers.
   class rate_scoreboard;
      bit [1:0]           scale;
      bit [CNT_W-1:0]     calib_n;
      bit [7:0]           thresh;
      longint             sum[3];
      longint unsigned    sq_sum[3];
      longint unsigned    count;
      longint             bias[3];
      longint unsigned    sigma[3];
      bit                 cal;
      rate_rec_type       rates_due[$];
      int                 errors;

      function void clear();
         scale = 0;
         calib_n = 50;
         thresh = 0;
         count = 0;
         cal = 0;
         for (int a = 0; a < 3; a++) begin
            sum[a] = 0;
            sq_sum[a] = 0;
            bias[a] = 0;
            sigma[a] = 0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
         if (idx == CSR_SCALE) scale = val[1:0];
         else if (idx == CSR_CALIB) calib_n = val;
         else if (idx == CSR_THRESH) thresh = val[7:0];
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // close a calibration run: mean to bias, deviation to sigma
      function void close_calibration();
         longint unsigned n, nn, mag, m, s2, prod, sqv, v, q, r, var_q16;
         n = count;
         nn = n * n;
         for (int a = 0; a < 3; a++) begin
            s2 = (sum[a] < 0) ? -sum[a] : sum[a];
            mag = s2 << FRAC;
            m = (mag * 2 + n) / (2 * n);
            bias[a] = (sum[a] < 0) ? -longint'(m) : longint'(m);
            prod = n * sq_sum[a];
            sqv = s2 * s2;
            v = (prod > sqv) ? prod - sqv : 0;
            q = v / nn;
            r = v % nn;
            var_q16 = (q << (2 * FRAC)) + ((r << (2 * FRAC)) / nn);
            sigma[a] = int_root(var_q16);
            sum[a] = 0;
            sq_sum[a] = 0;
         end
         count = 0;
         cal = 1;
      endfunction

      function longint scale_rate(longint d);
         longint unsigned factor[4];
         longint unsigned mag, p;
         longint r;
         factor = '{128060, 256138, 511487, 1022991};
         mag = (d < 0) ? -d : d;
         p = (mag * factor[scale] + (64'd1 << 23)) >> 24;
         r = (d < 0) ? -longint'(p) : longint'(p);
         if (r > 1048575) r = 1048575;
         if (r < -1048576) r = -1048576;
         return r;
      endfunction

      function void note_sample(logic op, logic signed [RAW_W-1:0] rx,
                                logic signed [RAW_W-1:0] ry,
                                logic signed [RAW_W-1:0] rz);
         longint raw[3];
         longint d[3];
         longint unsigned n, mag;
         rate_rec_type rec;
         raw[0] = rx;
         raw[1] = ry;
         raw[2] = rz;
         if (op == OP_CALIB) begin
            n = calib_n;
            if (n == 0) n = 1;
            if (n > MAX_CALIB) n = MAX_CALIB;
            for (int a = 0; a < 3; a++) begin
               sum[a] += raw[a];
               sq_sum[a] += longint'(raw[a] * raw[a]);
            end
            count++;
            if (count >= n) close_calibration();
            return;
         end
         for (int a = 0; a < 3; a++) begin
            d[a] = raw[a] * 256;
            if (cal) d[a] -= bias[a];
            if (thresh > 0) begin
               mag = (d[a] < 0) ? -d[a] : d[a];
               if (mag < sigma[a] * thresh) d[a] = 0;
            end
         end
         rec.x = RATE_W'(scale_rate(d[0]));
         rec.y = RATE_W'(scale_rate(d[1]));
         rec.z = RATE_W'(scale_rate(d[2]));
         rec.cal = cal;
         rates_due.push_back(rec);
      endfunction

      function void check_rate(logic signed [RATE_W-1:0] x, logic signed [RATE_W-1:0] y,
                               logic signed [RATE_W-1:0] z, logic c);
         rate_rec_type e;
         if (rates_due.size() == 0) begin
            $error("unexpected rate transfer x=%0d y=%0d z=%0d", x, y, z);
            errors++;
            return;
         end
         e = rates_due.pop_front();
         if (x !== e.x) begin
            $error("rate_x expected %0d actual %0d", e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $error("rate_y expected %0d actual %0d", e.y, y);
            errors++;
         end
         if (z !== e.z) begin
            $error("rate_z expected %0d actual %0d", e.z, z);
            errors++;
         end
         if (c !== e.cal) begin
            $error("is_calibrated expected %0d actual %0d", e.cal, c);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic                     req_operation = 0;
   logic signed [RAW_W-1:0]  req_raw_x = 0;
   logic signed [RAW_W-1:0]  req_raw_y = 0;
   logic signed [RAW_W-1:0]  req_raw_z = 0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic signed [RATE_W-1:0] rsp_rate_x;
   logic signed [RATE_W-1:0] rsp_rate_y;
   logic signed [RATE_W-1:0] rsp_rate_z;
   logic                     rsp_is_calibrated;
   logic                     csr_write = 0;
   logic [1:0]               csr_index = 0;
   logic [CNT_W-1:0]         csr_data = 0;

   rate_scoreboard sb = new();
   bit             hold_rsp = 0;
   bit             no_idle = 0;
   int             idle_cycles = 0;

   gyro_calibrate_deadband_unit dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: toggle ready, with one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_ready <= 1;
         n = no_idle ? 20 : $urandom_range(1, 8);
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // check a rate transfer ahead of the edge that takes it
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_rate(rsp_rate_x, rsp_rate_y, rsp_rate_z, rsp_is_calibrated);
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // offer one sample and hold it until the transfer
   task automatic send_sample(logic op, logic signed [RAW_W-1:0] x,
                              logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
      bit taken;
      int gap;
      req_valid <= 1;
      req_operation <= op;
      req_raw_x <= x;
      req_raw_y <= y;
      req_raw_z <= z;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      sb.note_sample(op, x, y, z);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every rate, then let end-of-calibration math settle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.rates_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [CNT_W-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.write_reg(idx, val);
   endtask

   function automatic logic signed [RAW_W-1:0] pick_raw(int base, int spread);
      int v;
      case ($urandom_range(0, 11))
         0: v = -32768;
         1: v = 32767;
         2, 3: v = $signed($urandom_range(0, 65535)) - 32768;
         default: v = base + $signed($urandom_range(0, 2 * spread)) - spread;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[RAW_W-1:0];
   endfunction

   initial begin
      int base[3];
      int spread, n_items;
      logic op;
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // measure before any calibration, default registers
      send_sample(OP_MEASURE, 32767, -32768, 0);
      send_sample(OP_MEASURE, -1, 1, -32768);
      drain();

      // one-sample calibration (zero acts as one), full-scale inputs at widest scale
      write_csr(CSR_CALIB, 0);
      write_csr(CSR_SCALE, 3);
      send_sample(OP_CALIB, -32768, 32767, 0);
      drain();
      send_sample(OP_MEASURE, 32767, -32768, 0);
      send_sample(OP_MEASURE, -32768, 32767, 1);
      drain();

      // four-sample run with widest deadband
      write_csr(CSR_CALIB, 4);
      write_csr(CSR_THRESH, 255);
      write_csr(CSR_SCALE, 1);
      send_sample(OP_CALIB, 100, -50, 3);
      send_sample(OP_CALIB, 102, -49, 1);
      send_sample(OP_CALIB, 97, -52, 2);
      send_sample(OP_CALIB, 101, -51, 3);
      drain();
      send_sample(OP_MEASURE, 100, -50, 2);
      send_sample(OP_MEASURE, 32767, -32768, 100);
      // recalibration in progress keeps the old bias
      send_sample(OP_CALIB, 5, 5, 5);
      send_sample(OP_MEASURE, 110, -40, 12);
      drain();

      // oversize count clamps; lowering it ends the run on the next sample
      write_csr(CSR_THRESH, 1);
      write_csr(CSR_SCALE, 2);
      write_csr(CSR_CALIB, 2047);
      send_sample(OP_CALIB, 7, -7, 0);
      send_sample(OP_CALIB, -3, 9, 1);
      drain();
      write_csr(CSR_CALIB, 2);
      send_sample(OP_CALIB, 1, 1, 1);
      drain();
      send_sample(OP_MEASURE, 3, -3, 0);
      drain();

      // random phases with fresh settings each
      for (int ph = 0; ph < 11; ph++) begin
         write_csr(CSR_SCALE, CNT_W'($urandom_range(0, 3)));
         case ($urandom_range(0, 5))
            0: write_csr(CSR_CALIB, 1);
            1: write_csr(CSR_CALIB, 50);
            default: write_csr(CSR_CALIB, CNT_W'($urandom_range(2, 12)));
         endcase
         case ($urandom_range(0, 4))
            0: write_csr(CSR_THRESH, 0);
            1: write_csr(CSR_THRESH, 255);
            default: write_csr(CSR_THRESH, CNT_W'($urandom_range(1, 6)));
         endcase
         for (int a = 0; a < 3; a++) base[a] = $signed($urandom_range(0, 4000)) - 2000;
         spread = $urandom_range(0, 1) ? 8 : 600;
         no_idle = (ph % 4 == 1);
         if (ph == 3) hold_rsp = 1;
         n_items = 48;
         for (int i = 0; i < n_items; i++) begin
            op = ($urandom_range(0, 99) < 30) ? OP_CALIB : OP_MEASURE;
            send_sample(op, pick_raw(base[0], spread), pick_raw(base[1], spread),
                        pick_raw(base[2], spread));
         end
         no_idle = 0;
         drain();
      end

      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

### files.f
+incdir+src
src/gcd_pkg.sv
src/gcd_math.sv
src/gcd_datapath.sv
src/gcd_ctrl.sv
src/gyro_calibrate_deadband_unit.sv
src/gcd_checker.sv
tb/gyro_calibrate_deadband_unit_tb.sv
